FILE: rtl/gregorian_date_arithmetic_core_macros.svh
// Assertion helpers for the date core.
// Each macro expands to a labelled concurrent assertion in simulation and to
// nothing when SYNTH is defined.
`ifndef GREGORIAN_DATE_ARITHMETIC_CORE_MACROS_SVH
`define GREGORIAN_DATE_ARITHMETIC_CORE_MACROS_SVH

`ifndef SYNTH
`define GDA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("date core check failed");
`define GDA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("date core sequence check failed");
`else
`define GDA_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define GDA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/gda_pkg.sv
`default_nettype none

package gda_pkg;

    localparam logic [13:0] MAX_YEAR = 14'd9999;

    // Serial day number of January 1 of the year after the last legal one
    localparam int SERIAL_END_INT = 365 * (int'(MAX_YEAR) + 1) + (int'(MAX_YEAR) + 4) / 4
                                    - (int'(MAX_YEAR) + 100) / 100
                                    + (int'(MAX_YEAR) + 400) / 400;
    localparam logic [22:0] SERIAL_END = 23'(SERIAL_END_INT);

    // floor(x / 100) = (x * 5243) >> 19 for x below 43690
    localparam logic [12:0] DIV100_RECIP = 13'd5243;
    // Slightly low estimate of 400 / 146097 scaled by 2^24
    localparam logic [15:0] YEAR_RECIP   = 16'd45934;

    localparam logic signed [23:0] DIFF_MAX = 24'sd4194303;
    localparam logic signed [23:0] DIFF_MIN = -24'sd4194304;

    localparam logic [1:0] ACT_LOAD    = 2'd0;
    localparam logic [1:0] ACT_OFFSET  = 2'd1;
    localparam logic [1:0] ACT_COMPARE = 2'd2;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_RANGE   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        YSEL_CUR  = 2'd0,
        YSEL_GIV  = 2'd1,
        YSEL_YY   = 2'd2,
        YSEL_YY1  = 2'd3
    } ysel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CUR_REQ,
        S_CUR_WAIT,
        S_GIV_REQ,
        S_GIV_WAIT,
        S_CMP,
        S_OFF_ADD,
        S_EST,
        S_LO_REQ,
        S_LO_WAIT,
        S_HI_REQ,
        S_HI_WAIT,
        S_FIN_REQ,
        S_FIN_WAIT,
        S_MON,
        S_OUT
    } state_t;

    typedef struct packed {
        logic  capture;
        logic  yu_start;
        ysel_t yu_sel;
        logic  ld_ser_cur;
        logic  commit_load;
        logic  ld_giv;
        logic  set_invalid;
        logic  ld_cmp;
        logic  ld_sum;
        logic  set_range;
        logic  ld_est;
        logic  yy_dec;
        logic  yy_inc;
        logic  ld_rem;
        logic  mm_inc;
        logic  commit_offset;
        logic  out_load;
    } cmd_t;

    typedef struct packed {
        logic yu_done;
        logic giv_ok;
        logic out_of_range;
        logic below_start;
        logic beyond_next;
        logic month_step;
        logic out_free;
    } stat_t;

    // Days in the year before the first of month m
    function automatic logic [8:0] month_offset(input logic [3:0] m, input logic leap);
        logic [8:0] base;
        unique case (m)
            4'd1:    base = 9'd0;
            4'd2:    base = 9'd31;
            4'd3:    base = 9'd59;
            4'd4:    base = 9'd90;
            4'd5:    base = 9'd120;
            4'd6:    base = 9'd151;
            4'd7:    base = 9'd181;
            4'd8:    base = 9'd212;
            4'd9:    base = 9'd243;
            4'd10:   base = 9'd273;
            4'd11:   base = 9'd304;
            4'd12:   base = 9'd334;
            default: base = 9'd0;
        endcase
        return base + 9'((leap && (m > 4'd2)) ? 1 : 0);
    endfunction

    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [4:0] n;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                   n = 5'd30;
            4'd2:                                      n = leap ? 5'd29 : 5'd28;
            default:                                   n = 5'd0;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/gda_year_unit.sv
`default_nettype none

// Three-stage pipeline: serial of January 1 and leap flag of one year
module gda_year_unit
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [14:0] arg,
    output logic             done,
    output logic [22:0]      year_start,
    output logic             leap
);
    import gda_pkg::*;

    logic [14:0] arg_reg;
    logic        v1_reg;
    logic [14:0] arg2_reg;
    logic [8:0]  q_reg;
    logic [22:0] y365_reg;
    logic        v2_reg;
    logic [22:0] ys_reg;
    logic        leap_reg;
    logic        done_reg;

    logic [27:0] q_prod;
    logic [22:0] y365_next;
    logic [14:0] hundred_q;
    logic [14:0] r_wide;
    logic [6:0]  r;
    logic [12:0] ceil4;
    logic [8:0]  ceil100;
    logic [7:0]  ceil400;
    logic [22:0] ys_next;
    logic        leap_next;

    assign q_prod    = 28'(arg_reg) * 28'(DIV100_RECIP);
    assign y365_next = 23'(arg_reg) * 23'd365;

    assign hundred_q = 15'(q_reg) * 15'd100;
    assign r_wide    = arg2_reg - hundred_q;
    assign r         = r_wide[6:0];
    assign ceil4     = 13'(arg2_reg >> 2) + 13'((arg2_reg[1:0] != 2'b00) ? 1 : 0);
    assign ceil100   = q_reg + 9'((r != 7'd0) ? 1 : 0);
    assign ceil400   = 8'(q_reg >> 2) + 8'(((q_reg[1:0] != 2'b00) || (r != 7'd0)) ? 1 : 0);
    assign ys_next   = y365_reg + 23'(ceil4) + 23'(ceil400) - 23'(ceil100);
    assign leap_next = ((arg2_reg[1:0] == 2'b00) && (r != 7'd0))
                     || ((r == 7'd0) && (q_reg[1:0] == 2'b00));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start;
            v2_reg   <= v1_reg;
            done_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            arg_reg <= arg;
        end
        arg2_reg <= arg_reg;
        q_reg    <= q_prod[27:19];
        y365_reg <= y365_next;
        ys_reg   <= ys_next;
        leap_reg <= leap_next;
    end

    assign done       = done_reg;
    assign year_start = ys_reg;
    assign leap       = leap_reg;

endmodule

`default_nettype wire

FILE: rtl/gda_datapath.sv
`default_nettype none

module gda_datapath
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire gda_pkg::cmd_t       cmd,
    output gda_pkg::stat_t           stat,
    input  wire logic signed [20:0]  offset_days,
    input  wire logic [13:0]         other_year,
    input  wire logic [3:0]          other_month,
    input  wire logic [4:0]          other_day,
    input  wire logic                out_stall,
    output logic                     out_valid,
    output logic [13:0]              cur_year,
    output logic [3:0]               cur_month,
    output logic [4:0]               cur_day,
    output logic signed [22:0]       day_difference,
    output logic                     is_less,
    output logic                     is_equal,
    output logic                     is_greater,
    output logic [1:0]               status
);
    import gda_pkg::*;

    // stored date
    logic [13:0] year_reg;
    logic [3:0]  month_reg;
    logic [4:0]  day_reg;

    // captured beat
    logic signed [20:0] off_reg;
    logic [13:0]        gy_reg;
    logic [3:0]         gm_reg;
    logic [4:0]         gd_reg;

    logic [22:0]        ser_cur_reg;
    logic [22:0]        ser_giv_reg;
    logic signed [23:0] sum_reg;
    logic [14:0]        yy_reg;
    logic [8:0]         rem_reg;
    logic [3:0]         mm_reg;
    logic               fin_leap_reg;

    status_t            res_status_reg;
    logic signed [22:0] res_diff_reg;
    logic               res_lt_reg;
    logic               res_eq_reg;
    logic               res_gt_reg;

    logic               out_valid_reg;
    logic [13:0]        out_year_reg;
    logic [3:0]         out_month_reg;
    logic [4:0]         out_day_reg;
    logic signed [22:0] out_diff_reg;
    logic               out_lt_reg;
    logic               out_eq_reg;
    logic               out_gt_reg;
    status_t            out_status_reg;

    logic [14:0]        yu_arg;
    logic               yu_done;
    logic [22:0]        yu_ys;
    logic               yu_leap;

    logic [22:0]        ser_cur_next;
    logic [22:0]        ser_giv_next;
    logic signed [23:0] sum_next;
    logic signed [23:0] diff_full;
    logic signed [22:0] diff_sat;
    logic [38:0]        est_prod;
    logic [22:0]        rem_wide;
    logic [8:0]         day_wide;

    always_comb
    begin
        case (cmd.yu_sel)
            YSEL_CUR: yu_arg = {1'b0, year_reg};
            YSEL_GIV: yu_arg = {1'b0, gy_reg};
            YSEL_YY:  yu_arg = yy_reg;
            default:  yu_arg = yy_reg + 15'd1;
        endcase
    end

    gda_year_unit u_year
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (cmd.yu_start),
        .arg        (yu_arg),
        .done       (yu_done),
        .year_start (yu_ys),
        .leap       (yu_leap)
    );

    assign ser_cur_next = yu_ys + 23'(month_offset(month_reg, yu_leap)) + 23'(day_reg) - 23'd1;
    assign ser_giv_next = yu_ys + 23'(month_offset(gm_reg, yu_leap)) + 23'(gd_reg) - 23'd1;

    assign sum_next  = $signed({1'b0, ser_cur_reg}) + $signed({{3{off_reg[20]}}, off_reg});
    assign diff_full = $signed({1'b0, ser_cur_reg}) - $signed({1'b0, ser_giv_reg});

    always_comb
    begin
        if (diff_full > DIFF_MAX)
        begin
            diff_sat = DIFF_MAX[22:0];
        end
        else if (diff_full < DIFF_MIN)
        begin
            diff_sat = DIFF_MIN[22:0];
        end
        else
        begin
            diff_sat = diff_full[22:0];
        end
    end

    assign est_prod = 39'(sum_reg[22:0]) * 39'(YEAR_RECIP);
    assign rem_wide = sum_reg[22:0] - yu_ys;
    assign day_wide = rem_reg - month_offset(mm_reg, fin_leap_reg) + 9'd1;

    assign stat.yu_done      = yu_done;
    assign stat.giv_ok       = (gy_reg <= MAX_YEAR) && (gd_reg != 5'd0)
                             && (gd_reg <= month_days(gm_reg, yu_leap));
    assign stat.out_of_range = sum_reg[23] || (sum_reg[22:0] >= SERIAL_END);
    assign stat.below_start  = (yy_reg != 15'd0) && (sum_reg[22:0] < yu_ys);
    assign stat.beyond_next  = sum_reg[22:0] >= yu_ys;
    assign stat.month_step   = (mm_reg < 4'd12)
                             && (rem_reg >= month_offset(mm_reg + 4'd1, fin_leap_reg));
    assign stat.out_free     = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            year_reg      <= 14'd0;
            month_reg     <= 4'd1;
            day_reg       <= 5'd1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit_load)
            begin
                year_reg  <= gy_reg;
                month_reg <= gm_reg;
                day_reg   <= gd_reg;
            end
            else if (cmd.commit_offset)
            begin
                year_reg  <= yy_reg[13:0];
                month_reg <= mm_reg;
                day_reg   <= day_wide[4:0];
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            off_reg        <= offset_days;
            gy_reg         <= other_year;
            gm_reg         <= other_month;
            gd_reg         <= other_day;
            res_status_reg <= ST_OK;
            res_diff_reg   <= 23'sd0;
            res_lt_reg     <= 1'b0;
            res_eq_reg     <= 1'b0;
            res_gt_reg     <= 1'b0;
        end
        if (cmd.set_invalid)
        begin
            res_status_reg <= ST_INVALID;
        end
        if (cmd.set_range)
        begin
            res_status_reg <= ST_RANGE;
        end
        if (cmd.ld_cmp)
        begin
            res_diff_reg <= diff_sat;
            res_lt_reg   <= diff_full[23];
            res_eq_reg   <= diff_full == 24'sd0;
            res_gt_reg   <= !diff_full[23] && (diff_full != 24'sd0);
        end
        if (cmd.ld_ser_cur)
        begin
            ser_cur_reg <= ser_cur_next;
        end
        if (cmd.ld_giv)
        begin
            ser_giv_reg <= ser_giv_next;
        end
        if (cmd.ld_sum)
        begin
            sum_reg <= sum_next;
        end
        if (cmd.ld_est)
        begin
            yy_reg <= est_prod[38:24];
        end
        else if (cmd.yy_dec)
        begin
            yy_reg <= yy_reg - 15'd1;
        end
        else if (cmd.yy_inc)
        begin
            yy_reg <= yy_reg + 15'd1;
        end
        if (cmd.ld_rem)
        begin
            rem_reg      <= rem_wide[8:0];
            mm_reg       <= 4'd1;
            fin_leap_reg <= yu_leap;
        end
        else if (cmd.mm_inc)
        begin
            mm_reg <= mm_reg + 4'd1;
        end
        if (cmd.out_load)
        begin
            out_year_reg   <= year_reg;
            out_month_reg  <= month_reg;
            out_day_reg    <= day_reg;
            out_diff_reg   <= res_diff_reg;
            out_lt_reg     <= res_lt_reg;
            out_eq_reg     <= res_eq_reg;
            out_gt_reg     <= res_gt_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign cur_year       = out_year_reg;
    assign cur_month      = out_month_reg;
    assign cur_day        = out_day_reg;
    assign day_difference = out_diff_reg;
    assign is_less        = out_lt_reg;
    assign is_equal       = out_eq_reg;
    assign is_greater     = out_gt_reg;
    assign status         = out_status_reg;

endmodule

`default_nettype wire

FILE: rtl/gda_ctrl.sv
`default_nettype none

module gda_ctrl
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire logic [1:0]     action,
    input  wire gda_pkg::stat_t stat,
    output gda_pkg::cmd_t       cmd
);
    import gda_pkg::*;

    state_t     state_reg;
    state_t     state_next;
    logic [1:0] act_reg;
    logic [1:0] act_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            act_reg   <= ACT_LOAD;
        end
        else
        begin
            state_reg <= state_next;
            act_reg   <= act_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        act_next   = act_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    act_next = action;
                    unique case (action) inside
                        ACT_LOAD:                state_next = S_GIV_REQ;
                        ACT_OFFSET, ACT_COMPARE: state_next = S_CUR_REQ;
                        default:                 state_next = S_OUT;
                    endcase
                end
            end
            S_CUR_REQ:  state_next = S_CUR_WAIT;
            S_CUR_WAIT:
            begin
                if (stat.yu_done)
                begin
                    state_next = (act_reg == ACT_OFFSET) ? S_OFF_ADD : S_GIV_REQ;
                end
            end
            S_GIV_REQ:  state_next = S_GIV_WAIT;
            S_GIV_WAIT:
            begin
                if (stat.yu_done)
                begin
                    if (stat.giv_ok && (act_reg == ACT_COMPARE))
                    begin
                        state_next = S_CMP;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
            end
            S_CMP:      state_next = S_OUT;
            S_OFF_ADD:  state_next = S_EST;
            S_EST:      state_next = stat.out_of_range ? S_OUT : S_LO_REQ;
            S_LO_REQ:   state_next = S_LO_WAIT;
            S_LO_WAIT:
            begin
                if (stat.yu_done)
                begin
                    state_next = stat.below_start ? S_LO_REQ : S_HI_REQ;
                end
            end
            S_HI_REQ:   state_next = S_HI_WAIT;
            S_HI_WAIT:
            begin
                if (stat.yu_done)
                begin
                    state_next = stat.beyond_next ? S_HI_REQ : S_FIN_REQ;
                end
            end
            S_FIN_REQ:  state_next = S_FIN_WAIT;
            S_FIN_WAIT:
            begin
                if (stat.yu_done)
                begin
                    state_next = S_MON;
                end
            end
            S_MON:
            begin
                if (!stat.month_step)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
            end
            S_CUR_REQ:
            begin
                cmd.yu_start = 1'b1;
                cmd.yu_sel   = YSEL_CUR;
            end
            S_CUR_WAIT:
            begin
                cmd.ld_ser_cur = stat.yu_done;
            end
            S_GIV_REQ:
            begin
                cmd.yu_start = 1'b1;
                cmd.yu_sel   = YSEL_GIV;
            end
            S_GIV_WAIT:
            begin
                if (stat.yu_done)
                begin
                    cmd.set_invalid = !stat.giv_ok;
                    cmd.commit_load = stat.giv_ok && (act_reg == ACT_LOAD);
                    cmd.ld_giv      = stat.giv_ok;
                end
            end
            S_CMP:
            begin
                cmd.ld_cmp = 1'b1;
            end
            S_OFF_ADD:
            begin
                cmd.ld_sum = 1'b1;
            end
            S_EST:
            begin
                cmd.set_range = stat.out_of_range;
                cmd.ld_est    = !stat.out_of_range;
            end
            S_LO_REQ:
            begin
                cmd.yu_start = 1'b1;
                cmd.yu_sel   = YSEL_YY;
            end
            S_LO_WAIT:
            begin
                cmd.yy_dec = stat.yu_done && stat.below_start;
            end
            S_HI_REQ:
            begin
                cmd.yu_start = 1'b1;
                cmd.yu_sel   = YSEL_YY1;
            end
            S_HI_WAIT:
            begin
                cmd.yy_inc = stat.yu_done && stat.beyond_next;
            end
            S_FIN_REQ:
            begin
                cmd.yu_start = 1'b1;
                cmd.yu_sel   = YSEL_YY;
            end
            S_FIN_WAIT:
            begin
                cmd.ld_rem = stat.yu_done;
            end
            S_MON:
            begin
                cmd.mm_inc        = stat.month_step;
                cmd.commit_offset = !stat.month_step;
            end
            S_OUT:
            begin
                cmd.out_load = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/gregorian_date_arithmetic_core.sv
// Channel  Handshake             Beat contents
// in       in_valid / in_stall   action, offset_days, other_year, other_month, other_day
// out      out_valid / out_stall cur_year, cur_month, cur_day, day_difference,
//                                is_less, is_equal, is_greater, status
//
// One beat at a time. The spare action goes straight to the result; a load runs one
// year pipeline pass on the given date; a compare runs one on the stored date and one on
// the given date; an offset runs one on the stored date, then, if in range, passes that
// find the year, one more that gives its start, and a month walk of one month per cycle.
// rst_n clears the stored date to 0000-01-01 and empties the output register.
// A stalled result holds in the output register; the next beat is taken meanwhile.
`default_nettype none

`include "gregorian_date_arithmetic_core_macros.svh"

module gregorian_date_arithmetic_core
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         action,
    input  wire logic signed [20:0] offset_days,
    input  wire logic [13:0]        other_year,
    input  wire logic [3:0]         other_month,
    input  wire logic [4:0]         other_day,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [13:0]             cur_year,
    output logic [3:0]              cur_month,
    output logic [4:0]              cur_day,
    output logic signed [22:0]      day_difference,
    output logic                    is_less,
    output logic                    is_equal,
    output logic                    is_greater,
    output logic [1:0]              status
);
    import gda_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    gda_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .action   (action),
        .stat     (stat),
        .cmd      (cmd)
    );

    gda_datapath u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .offset_days    (offset_days),
        .other_year     (other_year),
        .other_month    (other_month),
        .other_day      (other_day),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .cur_year       (cur_year),
        .cur_month      (cur_month),
        .cur_day        (cur_day),
        .day_difference (day_difference),
        .is_less        (is_less),
        .is_equal       (is_equal),
        .is_greater     (is_greater),
        .status         (status)
    );

    // busy right after taking a beat
    `GDA_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
    // stored date shown on the output is always a legal one
    `GDA_ASSERT_NOW(a_date_legal, clk, rst_n, out_valid,
        (cur_month >= 4'd1) && (cur_month <= 4'd12) && (cur_day != 5'd0))
    // at most one ordering flag, and only on a good compare
    `GDA_ASSERT_NOW(a_flags_consistent, clk, rst_n, out_valid,
        ($countones({is_less, is_equal, is_greater}) <= 1)
        && (!(is_less || is_equal || is_greater) || (status == ST_OK)))
    // year pipeline is never restarted while a pass is starting
    `GDA_ASSERT_NEXT(a_single_start, clk, rst_n, cmd.yu_start, !cmd.yu_start)

endmodule

`default_nettype wire
